// ----- sv/dqpal_pkg.sv -----
`default_nettype none

package dqpal_pkg;

   // Operation codes carried in the mode field of an input item
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_CHECK      = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] data_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       is_palindrome;
      logic [6:0] entry_count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHK_READ,
      ST_CHK_COMPARE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;       // take the item on the request port
      logic chk_advance;  // step both walk offsets inward
      logic chk_finish;   // emit the check result
      logic chk_result;   // palindrome flag for the finished check
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic chk_long;     // item is a check over two or more entries
      logic pair_match;   // registered pair of entries compares equal
      logic pair_last;    // current pair is the innermost one
   } dp_status_type;

endpackage

`default_nettype wire

// ----- sv/dqpal_ctrl.sv -----
`default_nettype none

module dqpal_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire dqpal_pkg::dp_status_type dp_status,
   output dqpal_pkg::dp_cmd_type        dp_cmd
);

   dqpal_pkg::ctrl_state_type state_ff;
   dqpal_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqpal_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dqpal_pkg::ST_IDLE: begin
            if (start && dp_status.chk_long) begin
               state_in = dqpal_pkg::ST_CHK_READ;
            end
         end
         dqpal_pkg::ST_CHK_READ: begin
            state_in = dqpal_pkg::ST_CHK_COMPARE;
         end
         dqpal_pkg::ST_CHK_COMPARE: begin
            if (!dp_status.pair_match || dp_status.pair_last) begin
               state_in = dqpal_pkg::ST_IDLE;
            end else begin
               state_in = dqpal_pkg::ST_CHK_READ;
            end
         end
         default: begin
            state_in = dqpal_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy                = 1'b1;
      dp_cmd.accept       = 1'b0;
      dp_cmd.chk_advance  = 1'b0;
      dp_cmd.chk_finish   = 1'b0;
      dp_cmd.chk_result   = 1'b0;
      unique case (state_ff)
         dqpal_pkg::ST_IDLE: begin
            busy          = 1'b0;
            dp_cmd.accept = start;
         end
         dqpal_pkg::ST_CHK_READ: begin
            busy = 1'b1;
         end
         dqpal_pkg::ST_CHK_COMPARE: begin
            // finish on first mismatch or after the innermost pair
            if (!dp_status.pair_match || dp_status.pair_last) begin
               dp_cmd.chk_finish = 1'b1;
               dp_cmd.chk_result = dp_status.pair_match;
            end else begin
               dp_cmd.chk_advance = 1'b1;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/dqpal_dp.sv -----
`default_nettype none

module dqpal_dp #(
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dqpal_pkg::req_item_type  req_item,
   input  wire dqpal_pkg::dp_cmd_type    dp_cmd,
   output dqpal_pkg::dp_status_type      dp_status,
   output logic                          rsp_strobe,
   output dqpal_pkg::rsp_item_type       rsp_item
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [31:0]   entry_store_ff [DEPTH];
   logic [31:0]   rd_lo_ff;
   logic [31:0]   rd_hi_ff;

   logic [AW-1:0] front_ff;
   logic [AW-1:0] front_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [AW-1:0] lo_ff;
   logic [AW-1:0] lo_in;
   logic [AW-1:0] hi_ff;
   logic [AW-1:0] hi_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   dqpal_pkg::rsp_item_type rsp_ff;
   dqpal_pkg::rsp_item_type rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_lo_addr;
   logic [AW-1:0] rd_hi_addr;
   logic [1:0]    op_status;
   logic          op_pal;
   logic          is_full;
   logic          is_empty;
   logic [31:0]   count_wide;
   logic [AW:0]   lo_plus_two;

   // Ring slot of an offset from the front; both inputs are below DEPTH
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                             input logic [AW-1:0] offset);
      logic [AW:0] sum;
      sum = {1'b0, front} + {1'b0, offset};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);

   assign rd_lo_addr = slot_of(front_ff, lo_ff);
   assign rd_hi_addr = slot_of(front_ff, hi_ff);

   assign lo_plus_two = {1'b0, lo_ff} + (AW + 1)'(2);

   assign dp_status.chk_long   = (req_item.mode == dqpal_pkg::MODE_CHECK)
                                 && (count_ff > CW'(1));
   assign dp_status.pair_match = (rd_lo_ff == rd_hi_ff);
   assign dp_status.pair_last  = (lo_plus_two >= {1'b0, hi_ff});

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      op_status = dqpal_pkg::STATUS_DONE;
      op_pal    = 1'b0;
      rsp_valid_in = 1'b0;

      if (dp_cmd.accept) begin
         rsp_valid_in = 1'b1;
         unique case (req_item.mode)
            dqpal_pkg::MODE_PUSH_FRONT: begin
               if (is_full) begin
                  op_status = dqpal_pkg::STATUS_FULL;
               end else begin
                  front_in = (front_ff == '0) ? LAST_SLOT : front_ff - AW'(1);
                  wr_en    = 1'b1;
                  wr_addr  = front_in;
                  count_in = count_ff + CW'(1);
               end
            end
            dqpal_pkg::MODE_PUSH_BACK: begin
               if (is_full) begin
                  op_status = dqpal_pkg::STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = slot_of(front_ff, count_ff[AW-1:0]);
                  count_in = count_ff + CW'(1);
               end
            end
            dqpal_pkg::MODE_POP_FRONT: begin
               if (is_empty) begin
                  op_status = dqpal_pkg::STATUS_EMPTY;
               end else begin
                  front_in = (front_ff == LAST_SLOT) ? '0 : front_ff + AW'(1);
                  count_in = count_ff - CW'(1);
               end
            end
            dqpal_pkg::MODE_POP_BACK: begin
               if (is_empty) begin
                  op_status = dqpal_pkg::STATUS_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            dqpal_pkg::MODE_CHECK: begin
               if (dp_status.chk_long) begin
                  // hold the result back until the walk ends
                  rsp_valid_in = 1'b0;
                  lo_in        = '0;
                  hi_in        = AW'(count_ff - CW'(1));
               end else begin
                  op_pal = 1'b1;
               end
            end
            default: begin
               op_status = dqpal_pkg::STATUS_DONE;
            end
         endcase
      end else if (dp_cmd.chk_advance) begin
         lo_in = lo_ff + AW'(1);
         hi_in = hi_ff - AW'(1);
      end else if (dp_cmd.chk_finish) begin
         rsp_valid_in = 1'b1;
         op_pal       = dp_cmd.chk_result;
      end

      count_wide           = 32'(count_in);
      rsp_in.status        = op_status;
      rsp_in.is_palindrome = op_pal;
      rsp_in.entry_count   = count_wide[6:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= req_item.data_value;
      end
      rd_lo_ff <= entry_store_ff[rd_lo_addr];
      rd_hi_ff <= entry_store_ff[rd_hi_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ----- sv/deque_with_palindrome_check_top.sv -----
`default_nettype none

// Double-ended queue of signed 32-bit values in a ring store of DEPTH entries, with a
// palindrome check. An item is taken when start is high and busy is low; its result
// appears on rsp_item for exactly one cycle, marked by rsp_strobe, in the cycle after
// the item's last working cycle, and must be captured then: the receiver cannot stall.
// Pushes, pops and unused modes keep busy low, so they run at one item per cycle. A
// check over n entries holds busy through a read state and a compare state for each
// compared pair, up to floor(n/2) pairs, and ends early on the first mismatch; with
// fewer than two entries it keeps busy low. Each pair is read by the registered two-port
// read of the entry store and then compared. A push on a full store is dropped with
// status 1, a pop on an empty store is ignored with status 2.
module deque_with_palindrome_check_top #(
   parameter int DEPTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire dqpal_pkg::req_item_type req_item,
   output logic                         rsp_strobe,
   output dqpal_pkg::rsp_item_type      rsp_item
);

   dqpal_pkg::dp_cmd_type    dp_cmd;
   dqpal_pkg::dp_status_type dp_status;

   dqpal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   dqpal_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import dqpal_pkg::*;

   localparam int DEPTH = 64;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = DEPTH + 8;

   // Codes that the block does not use; it must leave its state alone for them
   localparam logic [2:0] MODE_SPARE_A = 3'd5;
   localparam logic [2:0] MODE_SPARE_B = 3'd6;
   localparam logic [2:0] MODE_SPARE_C = 3'd7;

   class deque_scoreboard;
      logic [31:0]  ring [DEPTH];
      int unsigned  front_slot;
      int unsigned  count;
      rsp_item_type expected_q[$];
      int unsigned  fails;

      function new();
         front_slot = 0;
         count = 0;
         fails = 0;
      endfunction

      function int unsigned slot_at(int unsigned offset);
         return (front_slot + offset) % DEPTH;
      endfunction

      // Walk inward from both ends; fewer than two entries always reads the same
      function logic reads_same_both_ways();
         int unsigned lo;
         int unsigned hi;
         if (count < 2)
            return 1'b1;
         lo = 0;
         hi = count - 1;
         while (lo < hi) begin
            if (ring[slot_at(lo)] != ring[slot_at(hi)])
               return 1'b0;
            lo++;
            hi--;
         end
         return 1'b1;
      endfunction

      function void note_item(req_item_type item);
         rsp_item_type r;
         r = '0;
         r.status = STATUS_DONE;
         case (item.mode)
            MODE_PUSH_FRONT: begin
               if (count >= DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  front_slot = (front_slot + DEPTH - 1) % DEPTH;
                  ring[front_slot] = item.data_value;
                  count++;
               end
            end
            MODE_PUSH_BACK: begin
               if (count >= DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  ring[slot_at(count)] = item.data_value;
                  count++;
               end
            end
            MODE_POP_FRONT: begin
               if (count == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  front_slot = (front_slot + 1) % DEPTH;
                  count--;
               end
            end
            MODE_POP_BACK: begin
               if (count == 0)
                  r.status = STATUS_EMPTY;
               else
                  count--;
            end
            MODE_CHECK: begin
               r.is_palindrome = reads_same_both_ways();
            end
            default: begin
            end
         endcase
         r.entry_count = count[6:0];
         expected_q.push_back(r);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected: status %0d pal %0b count %0d",
                     $time, got.status, got.is_palindrome, got.entry_count);
            fails++;
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, got.status);
            fails++;
         end
         if (got.is_palindrome !== want.is_palindrome) begin
            $display("%0t: is_palindrome expected %0b actual %0b",
                     $time, want.is_palindrome, got.is_palindrome);
            fails++;
         end
         if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, got.entry_count);
            fails++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   deque_scoreboard sb = new();
   int unsigned     cycle_count;
   int unsigned     items_sent;
   int unsigned     idle_max;

   deque_with_palindrome_check_top #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_item);
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         // narrow range so that chance equalities occur
         2, 3: return {{30{1'b0}}, 2'($urandom_range(0, 3))};
         default: return $urandom();
      endcase
   endfunction

   task automatic send(logic [2:0] mode, logic [31:0] value);
      req_item_type item;
      int unsigned  gap;
      item.mode = mode;
      item.data_value = value;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         // idle with junk on the item port
         start <= 1'b0;
         req_item <= {3'($urandom()), 32'($urandom())};
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      do
         @(posedge clock);
      while (busy);
      sb.note_item(item);
      items_sent++;
   endtask

   task automatic pop_any();
      send($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK, $urandom());
   endtask

   task automatic drain(int unsigned extra);
      while (sb.count > 0) begin
         if ($urandom_range(0, 7) == 0)
            send(MODE_CHECK, $urandom());
         pop_any();
      end
      repeat (extra) pop_any();
   endtask

   // Grow a mirrored sequence pair by pair, optionally spoiling one pair
   task automatic palindrome_round();
      int unsigned pairs;
      int unsigned spoilt;
      logic [31:0] v;
      logic [31:0] w;
      if ($urandom_range(0, 3) != 0)
         drain(0);
      pairs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, DEPTH / 2)
                                          : $urandom_range(0, 6);
      spoilt = ($urandom_range(0, 2) == 0) ? $urandom_range(0, pairs) : DEPTH;
      if ($urandom_range(0, 1))
         send(MODE_PUSH_BACK, pick_value());
      for (int unsigned i = 0; i < pairs; i++) begin
         v = pick_value();
         w = (i == spoilt) ? v ^ (32'h1 << $urandom_range(0, 31)) : v;
         if ($urandom_range(0, 1)) begin
            send(MODE_PUSH_FRONT, v);
            send(MODE_PUSH_BACK, w);
         end else begin
            send(MODE_PUSH_BACK, w);
            send(MODE_PUSH_FRONT, v);
         end
      end
      send(MODE_CHECK, $urandom());
      // trim symmetric pairs and re-check
      repeat ($urandom_range(0, 3)) begin
         send(MODE_POP_FRONT, $urandom());
         send(MODE_POP_BACK, $urandom());
         send(MODE_CHECK, $urandom());
      end
   endtask

   task automatic fill_round();
      logic        same;
      logic [31:0] v;
      same = $urandom_range(0, 1);
      v = pick_value();
      while (sb.count < DEPTH)
         send($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
              same ? v : pick_value());
      repeat ($urandom_range(1, 3))
         send($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, pick_value());
      send(MODE_CHECK, $urandom());
      drain($urandom_range(1, 3));
   endtask

   task automatic noise_round();
      repeat ($urandom_range(5, 20))
         send(3'($urandom_range(0, 7)), $urandom());
   endtask

   initial begin
      int unsigned target;
      cycle_count = 0;
      items_sent = 0;
      idle_max = 7;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send(MODE_CHECK, 32'h0);
      send(MODE_POP_FRONT, 32'hFFFF_FFFF);
      send(MODE_POP_BACK, 32'h0);
      send(MODE_PUSH_FRONT, 32'h8000_0000);
      send(MODE_CHECK, 32'h0);
      send(MODE_PUSH_BACK, 32'h7FFF_FFFF);
      send(MODE_CHECK, 32'h0);
      send(MODE_POP_BACK, 32'h0);
      send(MODE_PUSH_BACK, 32'h8000_0000);
      send(MODE_CHECK, 32'hFFFF_FFFF);
      send(MODE_SPARE_A, 32'hFFFF_FFFF);
      send(MODE_SPARE_B, 32'h0);
      send(MODE_SPARE_C, 32'h5555_AAAA);
      send(MODE_POP_FRONT, 32'h0);
      send(MODE_POP_FRONT, 32'h0);
      send(MODE_POP_BACK, 32'h0);
      send(MODE_PUSH_FRONT, 32'h0);
      send(MODE_PUSH_BACK, 32'h0);
      send(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
      send(MODE_CHECK, 32'h0);
      send(MODE_PUSH_BACK, 32'hFFFF_FFFF);
      send(MODE_CHECK, 32'h0);
      drain(1);

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
         case ($urandom_range(0, 9))
            0: fill_round();
            1, 2: noise_round();
            default: palindrome_round();
         endcase
      end

      start <= 1'b0;
      while (sb.pending() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/dqpal_pkg.sv
sv/dqpal_ctrl.sv
sv/dqpal_dp.sv
sv/deque_with_palindrome_check_top.sv
test/testbench.sv
